>>> sv/led_matrix_scan_refresh_top_assert.svh
// assertion macros shared by the scan refresh modules
`ifndef LED_MATRIX_SCAN_REFRESH_TOP_ASSERT_SVH
`define LED_MATRIX_SCAN_REFRESH_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LMSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LMSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lmsr_pkg.sv
package lmsr_pkg;

    localparam int MAX_PANELS_WIDE = 2;
    localparam int MAX_PANELS_HIGH = 2;
    localparam int PANEL_COLUMNS   = 32;
    localparam int PANEL_ROWS      = 16;
    localparam int BUF_BYTES       = (MAX_PANELS_WIDE * PANEL_COLUMNS / 8)
                                     * (MAX_PANELS_HIGH * PANEL_ROWS);
    localparam int STORE_DEPTH     = 2 * BUF_BYTES;
    localparam int STORE_AW        = $clog2(STORE_DEPTH);
    localparam int BUF_AW          = $clog2(BUF_BYTES);

    localparam logic [7:0] FILL_BYTE = 8'hFF;

    // operation codes of an input request
    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_SWAP      = 2'd1;
    localparam logic [1:0] OP_SWAP_COPY = 2'd2;
    localparam logic [1:0] OP_REFRESH   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PANELS_WIDE   = 2'd0;
    localparam logic [1:0] CFG_PANELS_HIGH   = 2'd1;
    localparam logic [1:0] CFG_DOUBLE_BUFFER = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] address;
        logic [7:0] data;
        logic       bus_busy;
    } t_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] row_phase;
        logic       last;
    } t_result;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_SWAP,
        CMD_SWAP_COPY,
        CMD_REFRESH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] addr;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic fill;
        logic set_select;
        logic select_value;
    } t_cfg_evt;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_REFRESH
    } t_back_state;

    function automatic logic [7:0] bit_rev(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

    function automatic logic [1:0] clamp_panels(input logic [1:0] v, input logic [1:0] max_v);
        logic [1:0] r;
        r = v;
        if (v == 2'd0) begin
            r = 2'd1;
        end else if (v > max_v) begin
            r = max_v;
        end
        return r;
    endfunction

endpackage

>>> sv/led_matrix_scan_refresh_top.sv
// channel   direction  handshake               payload
// request   in         i_start and !o_busy     i_item   (lmsr_pkg::t_item)
// result    out        o_strobe, one cycle     o_result (lmsr_pkg::t_result)
// config    in         i_cfg_we                i_cfg_index, i_cfg_wdata
//
// byte writes and swaps pass the request queue and retire one per cycle in the scan engine
// while it is idle; a refresh gives 4 * stride * bands bytes, one a cycle; the request passes
// the queue, the engine state and the registered store read before its first byte is on the outputs
// swap and copy holds the engine until each copied byte, the last included, is written
// after reset the whole frame store is swept to all ones; enabling double buffering sweeps
// buffer one; o_busy rises only when the queue is full, and the receiver cannot stall
module led_matrix_scan_refresh_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  lmsr_pkg::t_item   i_item,
    output logic              o_strobe,
    output lmsr_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [1:0]        i_cfg_wdata
);

    import lmsr_pkg::*;

    logic       r_double_buffer;
    logic [1:0] r_panels_wide;
    logic [1:0] r_panels_high;
    t_cfg_evt   cfg_evt;
    logic       db_toggle;

    logic q_full;
    logic q_valid;
    logic q_push;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd head_cmd;

    assign db_toggle = i_cfg_we && (i_cfg_index == CFG_DOUBLE_BUFFER)
                       && (i_cfg_wdata[0] != r_double_buffer);

    always_comb begin
        cfg_evt.fill         = db_toggle && i_cfg_wdata[0];
        cfg_evt.set_select   = db_toggle;
        cfg_evt.select_value = i_cfg_wdata[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panels_wide   <= 2'd1;
            r_panels_high   <= 2'd1;
            r_double_buffer <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PANELS_WIDE) begin
                r_panels_wide <= clamp_panels(i_cfg_wdata, 2'(MAX_PANELS_WIDE));
            end
            if (i_cfg_index == CFG_PANELS_HIGH) begin
                r_panels_high <= clamp_panels(i_cfg_wdata, 2'(MAX_PANELS_HIGH));
            end
            if (i_cfg_index == CFG_DOUBLE_BUFFER) begin
                r_double_buffer <= i_cfg_wdata[0];
            end
        end
    end

    lmsr_front u_front (
        .i_start        (i_start),
        .i_item         (i_item),
        .i_double_buffer(r_double_buffer),
        .i_full         (q_full),
        .o_busy         (o_busy),
        .o_push         (q_push),
        .o_cmd          (front_cmd)
    );

    lmsr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (front_cmd),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_cmd  (head_cmd)
    );

    lmsr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .i_cmd          (head_cmd),
        .o_pop          (q_pop),
        .i_cfg_evt      (cfg_evt),
        .i_panels_wide  (r_panels_wide),
        .i_panels_high  (r_panels_high),
        .i_double_buffer(r_double_buffer),
        .o_strobe       (o_strobe),
        .o_result       (o_result)
    );

endmodule

>>> sv/lmsr_ram.sv
module lmsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/lmsr_front.sv
module lmsr_front (
    input  logic           i_start,
    input  lmsr_pkg::t_item i_item,
    input  logic           i_double_buffer,
    input  logic           i_full,
    output logic           o_busy,
    output logic           o_push,
    output lmsr_pkg::t_cmd o_cmd
);

    import lmsr_pkg::*;

    logic keep;

    // swaps without double buffering and refreshes on a busy bus are dropped here
    always_comb begin
        o_cmd.addr = i_item.address;
        o_cmd.data = i_item.data;
        unique case (i_item.operation)
            OP_WRITE: begin
                o_cmd.kind = CMD_WRITE;
                keep       = 1'b1;
            end
            OP_SWAP: begin
                o_cmd.kind = CMD_SWAP;
                keep       = i_double_buffer;
            end
            OP_SWAP_COPY: begin
                o_cmd.kind = CMD_SWAP_COPY;
                keep       = i_double_buffer;
            end
            OP_REFRESH: begin
                o_cmd.kind = CMD_REFRESH;
                keep       = !i_item.bus_busy;
            end
        endcase
    end

    assign o_busy = i_full;
    assign o_push = i_start && !i_full && keep;

endmodule

>>> sv/lmsr_queue.sv
`include "led_matrix_scan_refresh_top_assert.svh"

module lmsr_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lmsr_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output lmsr_pkg::t_cmd o_cmd
);

    import lmsr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_entries [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        priority if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entries[r_rd_ptr];

    `LMSR_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, o_full, !i_push, "push into full queue")
    `LMSR_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, !o_valid, !i_pop, "pop from empty queue")

endmodule

>>> sv/lmsr_back.sv
`include "led_matrix_scan_refresh_top_assert.svh"

module lmsr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  lmsr_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    input  lmsr_pkg::t_cfg_evt i_cfg_evt,
    input  logic [1:0]         i_panels_wide,
    input  logic [1:0]         i_panels_high,
    input  logic               i_double_buffer,
    output logic               o_strobe,
    output lmsr_pkg::t_result  o_result
);

    import lmsr_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic                r_render_sel;
    logic                n_render_sel;
    logic [1:0]          r_phase;
    logic [1:0]          n_phase;
    logic [STORE_AW-1:0] r_clr_addr;
    logic [STORE_AW-1:0] n_clr_addr;
    logic                r_band;
    logic                n_band;
    logic [2:0]          r_x;
    logic [2:0]          n_x;
    logic [1:0]          r_k;
    logic [1:0]          n_k;
    logic [BUF_AW-1:0]   r_cp_idx;
    logic [BUF_AW-1:0]   n_cp_idx;
    logic                r_cp_valid;
    logic                n_cp_valid;
    logic [STORE_AW-1:0] r_cp_waddr;
    logic [STORE_AW-1:0] n_cp_waddr;
    logic                r_rd_valid;
    logic                r_rd_flip;
    logic                r_rd_last;
    logic [1:0]          r_rd_phase;

    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [7:0]          ram_wdata;
    logic [STORE_AW-1:0] ram_raddr;
    logic [7:0]          ram_rdata;

    logic              wide2;
    logic              high2;
    logic              shown_sel;
    logic              flip;
    logic              x_end;
    logic              rf_last;
    logic [3:0]        row_lo;
    logic [2:0]        col;
    logic [7:0]        rf_idx;
    logic [BUF_AW-1:0] cp_last_idx;
    logic              cp_last;

    assign wide2     = (i_panels_wide == 2'd2);
    assign high2     = (i_panels_high == 2'd2);
    assign shown_sel = i_double_buffer && !r_render_sel;

    // with two bands the top one is mounted upside down
    assign flip    = high2 && !r_band;
    assign x_end   = (r_x == {wide2, 2'b11});
    assign rf_last = (r_band == high2) && x_end && (r_k == 2'd0);
    // 15 - (phase + 4k) is the bitwise complement in four bits
    assign row_lo  = {r_k, r_phase} ^ {4{flip}};
    assign col     = flip ? (r_x ^ {wide2, 2'b11}) : r_x;
    assign rf_idx  = wide2 ? {r_band, row_lo, col} : {1'b0, r_band, row_lo, col[1:0]};

    assign cp_last_idx = {wide2 && high2, wide2 || high2, {(BUF_AW - 2){1'b1}}};
    assign cp_last     = (r_cp_idx == cp_last_idx);

    assign o_pop = (r_state == ST_IDLE) && i_cmd_valid && !r_cp_valid && !i_cfg_evt.fill;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                priority if (i_cfg_evt.fill) begin
                    n_state = ST_CLEAR;
                end else if (o_pop && i_cmd.kind == CMD_SWAP_COPY) begin
                    n_state = ST_COPY;
                end else if (o_pop && i_cmd.kind == CMD_REFRESH) begin
                    n_state = ST_REFRESH;
                end else begin
                    n_state = r_state;
                end
            end
            ST_COPY: begin
                priority if (i_cfg_evt.fill) begin
                    n_state = ST_CLEAR;
                end else if (cp_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = r_state;
                end
            end
            ST_REFRESH: begin
                priority if (i_cfg_evt.fill) begin
                    n_state = ST_CLEAR;
                end else if (rf_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = r_state;
                end
            end
        endcase
    end

    // datapath and store control
    always_comb begin
        n_render_sel = r_render_sel;
        n_phase      = r_phase;
        n_clr_addr   = r_clr_addr;
        n_band       = r_band;
        n_x          = r_x;
        n_k          = r_k;
        n_cp_idx     = r_cp_idx;
        n_cp_waddr   = {r_render_sel, r_cp_idx};
        n_cp_valid   = (r_state == ST_COPY);
        ram_we       = 1'b0;
        ram_waddr    = r_clr_addr;
        ram_wdata    = FILL_BYTE;
        ram_raddr    = {shown_sel, rf_idx};

        priority if (r_state == ST_CLEAR) begin
            ram_we     = 1'b1;
            n_clr_addr = r_clr_addr + 1'b1;
        end else if (r_cp_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_cp_waddr;
            ram_wdata = ram_rdata;
        end else if (o_pop && i_cmd.kind == CMD_WRITE) begin
            ram_we    = 1'b1;
            ram_waddr = {r_render_sel, i_cmd.addr};
            ram_wdata = i_cmd.data;
        end else begin
            ram_we    = 1'b0;
        end

        if (o_pop) begin
            unique case (i_cmd.kind)
                CMD_WRITE: begin
                end
                CMD_SWAP: begin
                    n_render_sel = !r_render_sel;
                end
                CMD_SWAP_COPY: begin
                    n_render_sel = !r_render_sel;
                    n_cp_idx     = '0;
                end
                CMD_REFRESH: begin
                    n_band = 1'b0;
                    n_x    = '0;
                    n_k    = 2'd3;
                end
            endcase
        end

        if (r_state == ST_COPY) begin
            ram_raddr = {!r_render_sel, r_cp_idx};
            n_cp_idx  = r_cp_idx + 1'b1;
        end

        if (r_state == ST_REFRESH) begin
            if (r_k != 2'd0) begin
                n_k = r_k - 1'b1;
            end else begin
                n_k = 2'd3;
                if (x_end) begin
                    n_x    = '0;
                    n_band = !r_band;
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            if (rf_last) begin
                n_phase = r_phase + 1'b1;
            end
        end

        // a fill that comes during a sweep is left to that sweep, which runs on to the end of the store
        if (i_cfg_evt.fill && r_state != ST_CLEAR) begin
            n_clr_addr = STORE_AW'(BUF_BYTES);
        end
        if (i_cfg_evt.set_select) begin
            n_render_sel = i_cfg_evt.select_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_render_sel <= 1'b0;
            r_phase      <= '0;
            r_clr_addr   <= '0;
            r_cp_valid   <= 1'b0;
            r_rd_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_render_sel <= n_render_sel;
            r_phase      <= n_phase;
            r_clr_addr   <= n_clr_addr;
            r_cp_valid   <= n_cp_valid;
            r_rd_valid   <= (r_state == ST_REFRESH);
        end
    end

    always_ff @(posedge i_clk) begin
        r_band     <= n_band;
        r_x        <= n_x;
        r_k        <= n_k;
        r_cp_idx   <= n_cp_idx;
        r_cp_waddr <= n_cp_waddr;
        r_rd_flip  <= flip;
        r_rd_last  <= (r_state == ST_REFRESH) && rf_last;
        r_rd_phase <= r_phase;
    end

    lmsr_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_strobe           = r_rd_valid;
    assign o_result.data_byte = r_rd_flip ? bit_rev(ram_rdata) : ram_rdata;
    assign o_result.row_phase = r_rd_last ? r_rd_phase : 2'd0;
    assign o_result.last      = r_rd_last;

    `LMSR_ASSERT_SAME(a_copy_write_no_pop, i_clk, i_rst_n, r_cp_valid, !o_pop, "pop during copy write")
    `LMSR_ASSERT_SAME(a_no_write_in_scan, i_clk, i_rst_n, r_state == ST_REFRESH, !ram_we, "store written during refresh")
    `LMSR_ASSERT_NEXT(a_phase_step, i_clk, i_rst_n, (r_state == ST_REFRESH) && rf_last, r_phase == 2'($past(r_phase) + 2'd1), "phase did not advance after run")

endmodule
